@@ src/block_packing_allocator_top_macros.svh @@
`ifndef BLOCK_PACKING_ALLOCATOR_TOP_MACROS_SVH
`define BLOCK_PACKING_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bpa_pkg.sv @@
package bpa_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam logic [31:0] BLOCK_SIZE_RST = 32'd4096;

  typedef enum logic [1:0] {
    ST_PACKED = 2'd0,
    ST_NEW    = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WR_SUB
  } state_t;

  // One table entry as it is kept in the slot memory.
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
    logic [5:0]  owner;
    logic        is_sub;
  } slot_entry_t;

endpackage

@@ src/bpa_ram.sv @@
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bpa_alu.sv @@
module bpa_alu (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] limit,
  output logic [31:0] sum,
  output logic        fits
);

  logic [32:0] full_sum;

  // The carry is kept so that the fit test never sees a wrapped sum.
  assign full_sum = {1'b0, a} + {1'b0, b};
  assign sum      = full_sum[31:0];
  assign fits     = (full_sum <= {1'b0, limit});

endmodule

@@ src/block_packing_allocator_top.sv @@
// Slot-table allocator that packs small requests into existing host blocks.
// Input: raise start with in_req_size and in_fresh_block_addr; the word is
// taken at a clock edge where start is high and busy is low.
// Output: out_valid is high for exactly one cycle with out_alloc_addr,
// out_status, out_slot_index and out_owner_slot. The receiver cannot stall.
// Configuration: outside reset, cfg_wr_en writes cfg_wr_data into block_size
// at any edge; it should only change while the block is idle.
// Timing: one request scans every slot through the shared adder/compare
// unit, one slot per cycle out of the slot memory, so the block stays busy
// through S_SCAN and S_DECIDE (and S_WR_SUB when the request is packed,
// which needs a second memory write). The result strobe comes in the same
// cycle in which busy falls, and a new word may be started in that same cycle.
// Reset: after rst_n is released the block runs a clearing pass of
// every slot in the slot memory with busy high; block_size
// returns to 4096.
`include "block_packing_allocator_top_macros.svh"

module block_packing_allocator_top #(
  parameter int SLOT_COUNT = bpa_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_fresh_block_addr,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output logic        out_valid,
  output logic [31:0] out_alloc_addr,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot_index,
  output logic [5:0]  out_owner_slot
);

  import bpa_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int EW = $bits(slot_entry_t);

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r;
  logic          dvld_r;
  logic [IW-1:0] didx_r;
  logic [31:0]   blk_size_r;
  logic [31:0]   size_r;
  logic [31:0]   fresh_r;
  logic          free_fnd_r;
  logic [IW-1:0] free_idx_r;
  logic          host_fnd_r;
  logic [IW-1:0] host_idx_r;
  logic [31:0]   host_base_r;
  logic [31:0]   host_len_r;
  logic [31:0]   host_sum_r;
  logic [5:0]    host_own_r;
  logic [31:0]   addr_r;

  logic          out_valid_r;
  logic [31:0]   out_addr_r;
  status_t       out_status_r;
  logic [5:0]    out_idx_r;
  logic [5:0]    out_own_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  slot_entry_t   wr_ent;
  logic [EW-1:0] ram_rdata;
  slot_entry_t   rd_ent;

  logic [31:0]   alu_a;
  logic [31:0]   alu_b;
  logic [31:0]   alu_sum;
  logic          alu_fits;

  logic          scan_issue;
  logic          host_cand;
  logic          do_pack;

  bpa_ram #(
    .WIDTH(EW),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_ent),
    .raddr(cnt_r[IW-1:0]),
    .rdata(ram_rdata)
  );

  bpa_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .limit(blk_size_r),
    .sum  (alu_sum),
    .fits (alu_fits)
  );

  assign rd_ent     = slot_entry_t'(ram_rdata);
  assign scan_issue = (cnt_r < CW'(SLOT_COUNT));
  assign host_cand  = dvld_r && (rd_ent.base != 32'd0) && !rd_ent.is_sub && alu_fits;
  assign do_pack    = host_fnd_r && free_fnd_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (cnt_r == CW'(SLOT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_issue && dvld_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = do_pack ? S_WR_SUB : S_IDLE;
      end
      S_WR_SUB: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory write, adder operands and handshake.
  always_comb begin
    busy      = (state_r != S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IW-1:0];
    wr_ent    = '0;
    alu_a     = rd_ent.len;
    alu_b     = size_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_DECIDE: begin
        // The adder forms the packed address here: host base plus host fill.
        alu_a = host_base_r;
        alu_b = host_len_r;
        if (do_pack) begin
          ram_we        = 1'b1;
          ram_waddr     = host_idx_r;
          wr_ent.base   = host_base_r;
          wr_ent.len    = host_sum_r;
          wr_ent.owner  = host_own_r;
          wr_ent.is_sub = 1'b0;
        end else if (free_fnd_r) begin
          ram_we        = 1'b1;
          ram_waddr     = free_idx_r;
          wr_ent.base   = fresh_r;
          wr_ent.len    = size_r;
          wr_ent.owner  = 6'(free_idx_r);
          wr_ent.is_sub = 1'b0;
        end
      end
      S_WR_SUB: begin
        ram_we        = 1'b1;
        ram_waddr     = free_idx_r;
        wr_ent.base   = addr_r;
        wr_ent.len    = size_r;
        wr_ent.owner  = host_own_r;
        wr_ent.is_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      dvld_r      <= 1'b0;
      free_fnd_r  <= 1'b0;
      host_fnd_r  <= 1'b0;
      out_valid_r <= 1'b0;
      blk_size_r  <= BLOCK_SIZE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ((state_r == S_DECIDE) && !do_pack) || (state_r == S_WR_SUB);
      if (cfg_wr_en) begin
        blk_size_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + CW'(1);
        end
        S_IDLE: begin
          cnt_r  <= '0;
          dvld_r <= 1'b0;
          if (start) begin
            free_fnd_r <= 1'b0;
            host_fnd_r <= 1'b0;
          end
        end
        S_SCAN: begin
          dvld_r <= scan_issue;
          if (scan_issue) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (dvld_r && (rd_ent.base == 32'd0)) begin
            free_fnd_r <= 1'b1;
          end
          if (host_cand) begin
            host_fnd_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      size_r  <= in_req_size;
      fresh_r <= in_fresh_block_addr;
    end
    if (state_r == S_SCAN) begin
      didx_r <= cnt_r[IW-1:0];
      if (dvld_r && (rd_ent.base == 32'd0) && !free_fnd_r) begin
        free_idx_r <= didx_r;
      end
      // Only the first fitting host is kept.
      if (host_cand && !host_fnd_r) begin
        host_idx_r  <= didx_r;
        host_base_r <= rd_ent.base;
        host_len_r  <= rd_ent.len;
        host_sum_r  <= alu_sum;
        host_own_r  <= rd_ent.owner;
      end
    end
    if (state_r == S_DECIDE) begin
      if (do_pack) begin
        addr_r <= alu_sum;
      end else if (free_fnd_r) begin
        out_addr_r   <= fresh_r;
        out_status_r <= ST_NEW;
        out_idx_r    <= 6'(free_idx_r);
        out_own_r    <= 6'(free_idx_r);
      end else begin
        out_addr_r   <= 32'd0;
        out_status_r <= ST_FULL;
        out_idx_r    <= 6'd0;
        out_own_r    <= 6'd0;
      end
    end
    if (state_r == S_WR_SUB) begin
      out_addr_r   <= addr_r;
      out_status_r <= ST_PACKED;
      out_idx_r    <= 6'(free_idx_r);
      out_own_r    <= host_own_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alloc_addr = out_addr_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_idx_r;
  assign out_owner_slot = out_own_r;

  `BPA_ASSERT_NOW(a_full_zero,
                  out_valid && (out_status == ST_FULL),
                  (out_alloc_addr == 32'd0) && (out_slot_index == 6'd0) &&
                  (out_owner_slot == 6'd0),
                  "full result carries nonzero fields")
  `BPA_ASSERT_NEXT(a_accept_busy,
                   start && !busy,
                   busy && !out_valid,
                   "accepted word did not make the block busy")
  `BPA_ASSERT_NOW(a_result_after_busy,
                  out_valid,
                  $past(busy) && !busy,
                  "result strobe outside the end of a request")
  `BPA_ASSERT_NOW(a_pack_needs_free,
                  (state_r == S_WR_SUB),
                  free_fnd_r && host_fnd_r,
                  "packing without both a host and a free slot")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bpa_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 240;

  typedef struct packed {
    logic [31:0] addr;
    status_t     status;
    logic [5:0]  slot;
    logic [5:0]  owner;
  } alloc_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  // For a configuration row, req_size carries the new block size.
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] req_size;
    logic [31:0] fresh;
    bit          pinned;
    alloc_t      want;
  } step_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_req_size = '0;
  logic [31:0] in_fresh_block_addr = '0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        out_valid;
  logic [31:0] out_alloc_addr;
  logic [1:0]  out_status;
  logic [5:0]  out_slot_index;
  logic [5:0]  out_owner_slot;

  // Shadow copy of the slot table and of the block size.
  logic [31:0] exp_block_size;
  logic [31:0] tbl_base [SLOTS];
  logic [31:0] tbl_len [SLOTS];
  logic [5:0]  tbl_owner [SLOTS];
  logic        tbl_is_sub [SLOTS];

  alloc_t expected_allocs [$];
  int     err_count = 0;
  int     stall_cycles = 0;

  step_t directed_steps [18] = '{
    '{ROW_REQ, 32'h0000_0100, 32'h1000_0000, 1'b1, '{32'h1000_0000, ST_NEW, 6'd0, 6'd0}},
    '{ROW_REQ, 32'h0000_0200, 32'h2000_0000, 1'b1, '{32'h1000_0100, ST_PACKED, 6'd1, 6'd0}},
    '{ROW_REQ, 32'h0000_1000, 32'h3000_0000, 1'b1, '{32'h3000_0000, ST_NEW, 6'd2, 6'd2}},
    '{ROW_REQ, 32'h0000_1001, 32'h4000_0000, 1'b1, '{32'h4000_0000, ST_NEW, 6'd3, 6'd3}},
    '{ROW_REQ, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_REQ, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_NEW, 6'd5, 6'd5}},
    '{ROW_CFG, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
    '{ROW_REQ, 32'hFFFF_FFFF, 32'h5000_0000, 1'b0, '0},
    '{ROW_REQ, 32'hFFFF_F000, 32'h6000_0000, 1'b0, '0},
    // The first host only fits if the sum is allowed to wrap.
    '{ROW_REQ, 32'h0000_1000, 32'h6100_0000, 1'b0, '0},
    '{ROW_CFG, 32'h0000_0001, 32'h0, 1'b0, '0},
    '{ROW_REQ, 32'h0000_0100, 32'hFFFF_FF00, 1'b0, '0},
    '{ROW_REQ, 32'h0000_0000, 32'h5555_5555, 1'b0, '0},
    '{ROW_REQ, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_CFG, 32'h0000_0100, 32'h0, 1'b0, '0},
    // Packing into the host at the top of memory wraps the address to zero.
    '{ROW_REQ, 32'h0000_0000, 32'h7000_0000, 1'b0, '0},
    '{ROW_REQ, 32'h0000_0000, 32'h7100_0000, 1'b0, '0},
    '{ROW_REQ, 32'h0000_0200, 32'h8000_0000, 1'b0, '0}
  };

  block_packing_allocator_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_size         (in_req_size),
    .in_fresh_block_addr (in_fresh_block_addr),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_alloc_addr      (out_alloc_addr),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_owner_slot      (out_owner_slot)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int first_free();
    for (int k = 0; k < SLOTS; k++)
      if (tbl_base[k] == 32'd0) return k;
    return -1;
  endfunction

  function automatic int first_host(input logic [31:0] req_size);
    if (req_size > exp_block_size) return -1;
    for (int k = 0; k < SLOTS; k++)
      if (tbl_base[k] != 32'd0 && !tbl_is_sub[k] &&
          33'(tbl_len[k]) + 33'(req_size) <= 33'(exp_block_size))
        return k;
    return -1;
  endfunction

  function automatic alloc_t allocate(input logic [31:0] req_size, input logic [31:0] fresh);
    alloc_t res;
    int fs;
    int hs;
    fs = first_free();
    hs = first_host(req_size);
    if (hs >= 0 && fs >= 0) begin
      res.addr = tbl_base[hs] + tbl_len[hs];
      res.status = ST_PACKED;
      res.slot = 6'(fs);
      res.owner = tbl_owner[hs];
      tbl_len[hs] = tbl_len[hs] + req_size;
      tbl_is_sub[fs] = 1'b1;
      tbl_owner[fs] = res.owner;
      tbl_len[fs] = req_size;
      tbl_base[fs] = res.addr;
    end else if (fs >= 0) begin
      res.addr = fresh;
      res.status = ST_NEW;
      res.slot = 6'(fs);
      res.owner = 6'(fs);
      tbl_is_sub[fs] = 1'b0;
      tbl_owner[fs] = 6'(fs);
      tbl_len[fs] = req_size;
      tbl_base[fs] = fresh;
    end else begin
      res.addr = '0;
      res.status = ST_FULL;
      res.slot = '0;
      res.owner = '0;
    end
    return res;
  endfunction

  task automatic send_word(input logic [31:0] req_size, input logic [31:0] fresh,
                           input bit may_idle, input bit pinned, input alloc_t pinned_res);
    alloc_t res;
    @(negedge clk);
    if (may_idle && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 75)) @(negedge clk);
    end
    start <= 1'b1;
    in_req_size <= req_size;
    in_fresh_block_addr <= fresh;
    do @(posedge clk); while (busy !== 1'b0);
    res = allocate(req_size, fresh);
    expected_allocs.push_back(pinned ? pinned_res : res);
  endtask

  // The block is idle once the last result word has gone out and start is low.
  task automatic write_block_size(input logic [31:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (expected_allocs.size() != 0) @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    exp_block_size = value;
  endtask

  always @(posedge clk) begin
    alloc_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_allocs.size() == 0) begin
        $error("result word with nothing pending: alloc_addr %h status %0d",
               out_alloc_addr, out_status);
        err_count++;
      end else begin
        want = expected_allocs.pop_front();
        if (out_alloc_addr !== want.addr) begin
          $error("alloc_addr: expected %h, got %h", want.addr, out_alloc_addr);
          err_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
        if (out_slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, out_slot_index);
          err_count++;
        end
        if (out_owner_slot !== want.owner) begin
          $error("owner_slot: expected %0d, got %0d", want.owner, out_owner_slot);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] req_size;
    logic [31:0] fresh;
    logic [31:0] phase_bs [PHASES];
    bit consume_ok;
    bit consumes;
    int tries;
    int fs;
    int hs;

    exp_block_size = BLOCK_SIZE_RST;
    for (int k = 0; k < SLOTS; k++) begin
      tbl_base[k] = '0;
      tbl_len[k] = '0;
      tbl_owner[k] = '0;
      tbl_is_sub[k] = 1'b0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[n]) begin
      if (directed_steps[n].kind == ROW_CFG)
        write_block_size(directed_steps[n].req_size);
      else
        send_word(directed_steps[n].req_size, directed_steps[n].fresh, 1'b1,
                  directed_steps[n].pinned, directed_steps[n].want);
    end

    // The table never frees a slot, so most words are shaped to leave it as
    // it is: a new host at address zero keeps its slot free. Only a few words
    // may take a slot, which lets the table fill late in the run.
    phase_bs[0] = BLOCK_SIZE_RST;
    phase_bs[1] = 32'd1;
    phase_bs[2] = $urandom_range(2, 32'h0001_0000);
    phase_bs[3] = 32'h0000_0100;
    phase_bs[4] = $urandom_range(32'h0001_0000, 32'hFFFF_FFFE);
    phase_bs[5] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_block_size(phase_bs[ph]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        consume_ok = ($urandom_range(0, 23) == 0);
        tries = 0;
        do begin
          case ($urandom_range(0, 4))
            0: req_size = $urandom_range(0, 64);
            1: req_size = $urandom_range(0, 8192);
            2: req_size = exp_block_size + $urandom_range(0, 4) - 32'd2;
            3: req_size = $urandom;
            default: req_size = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : exp_block_size;
          endcase
          if (!consume_ok)
            fresh = 32'd0;
          else if ($urandom_range(0, 3) == 0)
            fresh = 32'd0 - req_size;
          else
            fresh = $urandom;
          fs = first_free();
          hs = first_host(req_size);
          if (fs < 0)
            consumes = 1'b0;
          else if (hs >= 0)
            consumes = (tbl_base[hs] + tbl_len[hs]) != 32'd0;
          else
            consumes = (fresh != 32'd0);
          tries++;
        end while (!consume_ok && consumes && tries < 16);
        send_word(req_size, fresh, ph != 2, 1'b0, '0);
      end
    end

    // Fill whatever is left of the table, then run words against a full one.
    while (first_free() >= 0)
      send_word($urandom_range(0, 4096), $urandom | 32'h0000_1000, 1'b1, 1'b0, '0);
    repeat (12) send_word($urandom, $urandom, 1'b1, 1'b0, '0);

    @(negedge clk);
    start <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
